>>> rtl/md5_stream_hash_defines.svh
// Assertion macros for the MD5 stream hasher.
`ifndef MD5_STREAM_HASH_DEFINES_SVH
`define MD5_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MD5_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MD5_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/md5_pkg.sv
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic        part_index;
        logic        last_part;
    } md5_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_COMP,
        ST_PAD,
        ST_OUT0,
        ST_OUT1
    } md5_state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       len_inc;
        logic       comp_start;
        logic       reinit;
        logic       sel_high;
    } md5_cmd_t;

    typedef struct packed {
        logic       comp_busy;
        logic       comp_done;
        logic [5:0] fill;
        logic [7:0] len_byte;
    } md5_status_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/md5_stream_hash.sv
// Streaming MD5 hasher. At most one message byte is taken per input beat; a beat with
// last set closes the message, and the block then returns the 16-byte digest
// as two 64-bit beats (bytes 0-7, then bytes 8-15, first byte in bits 7:0).
// A byte beat is written before the next beat is taken, and every 64th byte
// starts a compression, which runs one round per cycle on a single round unit.
// Closing a message writes one padding byte per cycle, pausing while a
// compression runs; it needs one or two compressions before the digest.
module md5_stream_hash
    import md5_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  md5_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output md5_out_t out_data
);

    md5_cmd_t    cmd;
    md5_status_t status;
    logic [63:0] digest_half;
    logic        out_hi;

    md5_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_hi    (out_hi),
        .status    (status),
        .cmd       (cmd)
    );

    md5_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .digest_half (digest_half)
    );

    assign out_data.digest_part = digest_half;
    assign out_data.part_index  = out_hi;
    assign out_data.last_part   = out_hi;

endmodule

>>> rtl/md5_datapath.sv
module md5_datapath
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  md5_cmd_t    cmd,
    output md5_status_t status,
    output logic [63:0] digest_half
);

    `include "md5_stream_hash_defines.svh"

    logic [31:0] buf_mem [16];
    logic [31:0] chain_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  fill_reg;
    logic [60:0] len_reg;
    logic [5:0]  round_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [63:0] bits;
    logic [1:0]  rsel;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [31:0] sum;
    logic [31:0] rot;
    logic [4:0]  sh;

    assign bits = {len_reg, 3'b000};
    assign rsel = round_reg[5:4];
    assign sh = round_s(round_reg);

    always_comb
    begin
        case (rsel)
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = round_reg[3:0];
            end
            2'd1:
            begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                g_idx = 4'(5 * round_reg[3:0] + 1);
            end
            2'd2:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = 4'(3 * round_reg[3:0] + 5);
            end
            default:
            begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = 4'(7 * round_reg[3:0]);
            end
        endcase
        sum = a_reg + f_val + round_k(round_reg) + buf_mem[g_idx];
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            buf_mem[fill_reg[5:2]][fill_reg[1:0]*8 +: 8] <= cmd.push_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
            fill_reg     <= '0;
            len_reg      <= '0;
            round_reg    <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.push)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.len_inc)
            begin
                len_reg <= len_reg + 61'd1;
            end
            if (cmd.comp_start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    busy_reg     <= 1'b0;
                    done_reg     <= 1'b1;
                    chain_reg[0] <= chain_reg[0] + d_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg + rot;
                    chain_reg[2] <= chain_reg[2] + b_reg;
                    chain_reg[3] <= chain_reg[3] + c_reg;
                end
            end
            if (cmd.reinit)
            begin
                chain_reg[0] <= INIT_A;
                chain_reg[1] <= INIT_B;
                chain_reg[2] <= INIT_C;
                chain_reg[3] <= INIT_D;
                fill_reg     <= '0;
                len_reg      <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (busy_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    always_comb
    begin
        status.comp_busy = busy_reg;
        status.comp_done = done_reg;
        status.fill      = fill_reg;
        status.len_byte  = bits[fill_reg[2:0]*8 +: 8];
        digest_half      = cmd.sel_high ? {chain_reg[3], chain_reg[2]}
                                        : {chain_reg[1], chain_reg[0]};
    end

    `MD5_ASSERT_IMPL(a_no_push_busy, clk, rst_n, busy_reg, !cmd.push)
    `MD5_ASSERT_NEXT(a_done_after_last, clk, rst_n, busy_reg && round_reg == 6'd63 && !cmd.comp_start, done_reg)
    `MD5_ASSERT_IMPL(a_start_idle, clk, rst_n, cmd.comp_start, !busy_reg)

endmodule

>>> rtl/md5_ctrl.sv
module md5_ctrl
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  md5_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_hi,
    input  md5_status_t status,
    output md5_cmd_t    cmd
);

    `include "md5_stream_hash_defines.svh"

    md5_state_t state_reg, state_next;
    logic       last_reg, last_next;
    logic [7:0] byte_reg, byte_next;
    logic       padded_reg, padded_next;
    logic       extra_reg, extra_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= 1'b0;
            padded_reg <= 1'b0;
            extra_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            padded_reg <= padded_next;
            extra_reg  <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        byte_next   = byte_reg;
        padded_next = padded_reg;
        extra_next  = extra_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_hi      = 1'b0;
        cmd         = '0;
        cmd.push_byte = byte_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next   = in_data.last;
                    byte_next   = in_data.data_byte;
                    padded_next = 1'b0;
                    extra_next  = 1'b0;
                    if (in_data.has_byte)
                    begin
                        state_next = ST_PUSH;
                    end
                    else if (in_data.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PUSH:
            begin
                cmd.push    = 1'b1;
                cmd.len_inc = 1'b1;
                if (status.fill == 6'd63)
                begin
                    cmd.comp_start = 1'b1;
                    state_next     = ST_COMP;
                end
                else
                begin
                    state_next = last_reg ? ST_PAD : ST_IDLE;
                end
            end
            ST_COMP:
            begin
                if (status.comp_done)
                begin
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (padded_reg && !extra_reg && status.fill == 6'd0)
                    begin
                        state_next = ST_OUT0;
                    end
                    else
                    begin
                        extra_next = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                if (!padded_reg)
                begin
                    cmd.push_byte = PAD_BYTE;
                    padded_next   = 1'b1;
                    extra_next    = (status.fill >= LEN_POS);
                end
                else if (status.fill < LEN_POS || extra_reg)
                begin
                    cmd.push_byte = 8'h00;
                end
                else
                begin
                    cmd.push_byte = status.len_byte;
                end
                if (status.fill == 6'd63)
                begin
                    cmd.comp_start = 1'b1;
                    state_next     = ST_COMP;
                end
            end
            ST_OUT0:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_OUT1;
                end
            end
            ST_OUT1:
            begin
                out_valid = 1'b1;
                out_hi    = 1'b1;
                cmd.sel_high = 1'b1;
                if (out_ready)
                begin
                    cmd.reinit = 1'b1;
                    last_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `MD5_ASSERT_IMPL(a_out_not_in, clk, rst_n, out_valid, !in_ready)
    `MD5_ASSERT_IMPL(a_out_last, clk, rst_n, out_valid, last_reg && padded_reg)
    `MD5_ASSERT_NEXT(a_part_order, clk, rst_n, state_reg == ST_OUT0 && out_ready, state_reg == ST_OUT1)

endmodule

>>> dv/md5_checker.sv
`timescale 1ns / 100ps

module md5_checker
    import md5_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  md5_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  md5_out_t out_data,
    output int       mismatches,
    output int       outstanding,
    output int       digests_seen
);

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0] chain [4];
    logic [31:0] block_words [16];
    logic [5:0]  fill;
    logic [60:0] msg_bytes;
    md5_out_t    digest_parts [$];

    task automatic restart_message();
        chain[0] = INIT_A;
        chain[1] = INIT_B;
        chain[2] = INIT_C;
        chain[3] = INIT_D;
        fill = '0;
        msg_bytes = '0;
    endtask

    task automatic compress_block();
        logic [31:0] a, b, c, d, f, t, sum;
        int g;
        int r;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            r = i / 16;
            case (r)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            sum = a + f + SINE_TAB[i] + block_words[g];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << ROT_TAB[r * 4 + i % 4]) | (sum >> (32 - ROT_TAB[r * 4 + i % 4])));
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endtask

    task automatic absorb_byte(input logic [7:0] v);
        block_words[fill[5:2]][fill[1:0] * 8 +: 8] = v;
        fill = fill + 6'd1;
        if (fill == 6'd0)
            compress_block();
    endtask

    task automatic predict_beat(input md5_in_t beat);
        logic [63:0] bit_len;
        md5_out_t part;
        if (beat.has_byte)
        begin
            absorb_byte(beat.data_byte);
            msg_bytes = msg_bytes + 61'd1;
        end
        if (beat.last)
        begin
            bit_len = {msg_bytes, 3'b000};
            absorb_byte(PAD_BYTE);
            while (fill != LEN_POS)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(bit_len[8 * i +: 8]);
            part.digest_part = {chain[1], chain[0]};
            part.part_index = 1'b0;
            part.last_part = 1'b0;
            digest_parts.push_back(part);
            part.digest_part = {chain[3], chain[2]};
            part.part_index = 1'b1;
            part.last_part = 1'b1;
            digest_parts.push_back(part);
            restart_message();
        end
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        digests_seen = 0;
        restart_message();
    end

    always @(posedge clk)
    begin
        md5_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (digest_parts.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = digest_parts.pop_front();
                    if (want.digest_part !== out_data.digest_part)
                    begin
                        $display("%0t: digest_part expected %h actual %h", $time,
                                 want.digest_part, out_data.digest_part);
                        mismatches++;
                    end
                    if (want.part_index !== out_data.part_index)
                    begin
                        $display("%0t: part_index expected %b actual %b", $time,
                                 want.part_index, out_data.part_index);
                        mismatches++;
                    end
                    if (want.last_part !== out_data.last_part)
                    begin
                        $display("%0t: last_part expected %b actual %b", $time,
                                 want.last_part, out_data.last_part);
                        mismatches++;
                    end
                    if (want.last_part)
                        digests_seen++;
                end
            end
            if (in_valid && in_ready)
                predict_beat(in_data);
            outstanding = digest_parts.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import md5_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    md5_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    md5_out_t out_data;
    int       mismatches;
    int       outstanding;
    int       digests_seen;

    int       send_idle;
    int       recv_idle;
    logic     hold_start;
    int       hold_left;
    int       beats_sent;
    int       messages_sent;

    md5_stream_hash u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    md5_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .digests_seen(digests_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            out_ready <= 1'b0;
            hold_left <= 3000;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic has, input logic fin);
        md5_in_t beat;
        int gap;
        beat.data_byte = b;
        beat.has_byte = has;
        beat.last = fin;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        if (has || fin)
            beats_sent++;
    endtask

    task automatic send_message(input int len, input bit empty_close);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 4)
                send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !empty_close);
        end
        if (empty_close || len == 0)
            send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
        messages_sent++;
    endtask

    initial
    begin
        int len;
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_start = 1'b0;
        send_idle = 24;
        recv_idle = 76;
        beats_sent = 0;
        messages_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_message(0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        messages_sent++;
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
        messages_sent++;
        send_beat(8'hff, 1'b1, 1'b1);
        messages_sent++;

        while (beats_sent < 1120)
        begin
            if (beats_sent > 370 && send_idle == 24)
            begin
                send_idle = 76;
                recv_idle = 24;
            end
            if (beats_sent > 740 && send_idle != 0)
            begin
                in_valid <= 1'b0;
                while (outstanding != 0)
                    @(posedge clk);
                send_idle = 0;
                recv_idle = 0;
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 65)
                len = $urandom_range(0, 40);
            else if (pick < 90)
                len = 55 + $urandom_range(0, 10) + 64 * $urandom_range(0, 1);
            else
                len = $urandom_range(128, 200);
            send_message(len, $urandom_range(3) == 0);
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Hashed %0d messages in %0d beats; %0d digests were checked.",
                 messages_sent, beats_sent, digests_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_datapath.sv
rtl/md5_ctrl.sv
rtl/md5_stream_hash.sv
dv/md5_checker.sv
dv/testbench.sv
